/* sv/sliding_window_median_macros.svh */
// ----------------------------------------------------------------------------
// Sliding window median assertion macros
// Clocked, reset-qualified wrappers for the concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/swm_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared widths, register map and the neighbor link type of the cell row.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int OUT_W          = 33;
	localparam int WS_W           = 7;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;

	localparam logic [WS_W-1:0] WS_RESET        = 7'd3;
	localparam logic [0:0]      REG_WINDOW_SIZE = 1'b0;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] val;
		logic                       flag;
	} nb_t;

endpackage

/* sv/swm_cell.sv */
// ----------------------------------------------------------------------------
// Sliding window median cell
// One slot of the sorted window: removes the oldest entry and inserts the
// new sample in one step, trading values with its two neighbors.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; #(
	parameter int IDX = 0,
	parameter int AW  = 6,
	parameter int CW  = 7
) (
	input  logic                       clk,
	input  logic                       load,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [AW-1:0]              k_age,
	input  logic                       evict,
	input  logic [CW-1:0]              n_cur,
	input  logic [CW-1:0]              n_keep,
	input  logic                       below,
	input  nb_t                        right_raw,
	input  logic [AW-1:0]              right_age,
	input  nb_t                        left_r,
	input  logic [AW-1:0]              left_r_age,
	output nb_t                        raw,
	output logic [AW-1:0]              age,
	output logic                       hit,
	output nb_t                        r_out,
	output logic [AW-1:0]              r_age
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic signed [SAMPLE_W-1:0] val_q;
	logic [AW-1:0]              age_q;
	logic signed [SAMPLE_W-1:0] val_nx;
	logic [AW-1:0]              age_nx;
	logic                       own_le;

	always_comb begin
		own_le    = (val_q <= sample);
		raw.val   = val_q;
		raw.flag  = own_le;
		age       = age_q;
		hit       = evict && (IDX_C < n_cur) && (age_q == k_age);
		r_out.val = below ? val_q : right_raw.val;
		r_age     = below ? age_q : right_age;
		r_out.flag = (IDX_C < n_keep) && (below ? own_le : right_raw.flag);
	end

	always_comb begin
		if (r_out.flag) begin
			val_nx = r_out.val;
			age_nx = r_age + AW'(1);
		end else if (left_r.flag) begin
			val_nx = sample;
			age_nx = '0;
		end else begin
			val_nx = left_r.val;
			age_nx = left_r_age + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= val_nx;
			age_q <= age_nx;
		end
	end

endmodule

/* sv/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// Sliding window median: one item per cycle unless in_stall holds the input.
// A row of WINDOW_MAX cells re-sorts the window in the accept cycle; the
// median is tapped from the row and registered once out_stall lets it move.
// Reset empties the window and sets window_size to 3; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median import swm_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       start_new,
	input  logic                       in_valid,
	output logic                       in_stall,
	output logic signed [OUT_W-1:0]    median_x2,
	output logic                       out_valid,
	input  logic                       out_stall
);

	localparam int N  = WINDOW_MAX;
	localparam int AW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);
	localparam int KW = (CW > WS_W) ? CW : WS_W;

	logic [WS_W-1:0]  ws_q;
	logic [CW-1:0]    fill_q;
	logic             pend_s1;
	logic             out_valid_q;
	logic signed [OUT_W-1:0] median_q;

	logic             cfg_wr;
	logic             accept;
	logic             move;
	logic [CW-1:0]    keff;
	logic [AW-1:0]    k_age;
	logic [CW-1:0]    n0;
	logic             evict;
	logic [CW-1:0]    n_keep;
	logic [CW-1:0]    n_new;
	logic             result;
	logic [CW-1:0]    lo_idx;
	logic [CW-1:0]    hi_idx;
	logic signed [SAMPLE_W-1:0] lo_v;
	logic signed [SAMPLE_W-1:0] hi_v;

	nb_t           raw   [N];
	logic [AW-1:0] age   [N];
	nb_t           rr    [N];
	logic [AW-1:0] rage  [N];
	logic [N-1:0]  hit_vec;
	logic [N-1:0]  below;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
	assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? DATA_W'(ws_q) : '0;

	always_comb begin
		if (ws_q == '0) begin
			keff = CW'(1);
		end else if (KW'(ws_q) > KW'(N)) begin
			keff = CW'(N);
		end else begin
			keff = CW'(ws_q);
		end
		k_age  = AW'(keff - CW'(1));
		n0     = start_new ? '0 : fill_q;
		if (n0 > keff) begin
			n0 = '0;
		end
		evict  = (n0 == keff);
		n_keep = n0 - CW'(evict);
		n_new  = n_keep + CW'(1);
		result = (n_new == keff);
		lo_idx = (keff - CW'(1)) >> 1;
		hi_idx = keff >> 1;
	end

	assign move     = pend_s1 && (!out_valid_q || !out_stall);
	assign in_stall = pend_s1 && !move;
	assign accept   = in_valid && !in_stall;

	for (genvar g = 0; g < N; g++) begin : g_cell
		nb_t           right_raw;
		logic [AW-1:0] right_age;
		nb_t           left_r;
		logic [AW-1:0] left_r_age;

		assign below[g] = ~|hit_vec[g:0];

		if (g == N - 1) begin : g_last
			assign right_raw = '0;
			assign right_age = '0;
		end else begin : g_mid
			assign right_raw = raw[g+1];
			assign right_age = age[g+1];
		end

		if (g == 0) begin : g_first
			assign left_r     = '{val: '0, flag: 1'b1};
			assign left_r_age = '0;
		end else begin : g_rest
			assign left_r     = rr[g-1];
			assign left_r_age = rage[g-1];
		end

		swm_cell #(
			.IDX (g),
			.AW  (AW),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.load       (accept),
			.sample     (sample),
			.k_age      (k_age),
			.evict      (evict),
			.n_cur      (n0),
			.n_keep     (n_keep),
			.below      (below[g]),
			.right_raw  (right_raw),
			.right_age  (right_age),
			.left_r     (left_r),
			.left_r_age (left_r_age),
			.raw        (raw[g]),
			.age        (age[g]),
			.hit        (hit_vec[g]),
			.r_out      (rr[g]),
			.r_age      (rage[g])
		);
	end

	always_comb begin
		lo_v = '0;
		hi_v = '0;
		for (int i = 0; i < N; i++) begin
			lo_v = lo_v | (raw[i].val & {SAMPLE_W{CW'(i) == lo_idx}});
			hi_v = hi_v | (raw[i].val & {SAMPLE_W{CW'(i) == hi_idx}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WS_RESET;
			fill_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				ws_q   <= pwdata[WS_W-1:0];
				fill_q <= '0;
			end else if (accept) begin
				fill_q <= n_new;
			end
			if (accept) begin
				pend_s1 <= result;
			end else if (move) begin
				pend_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			median_q <= OUT_W'(lo_v) + OUT_W'(hi_v);
		end
	end

	assign median_x2 = median_q;
	assign out_valid = out_valid_q;

endmodule

/* sv/swm_checker.sv */
// ----------------------------------------------------------------------------
// Sliding window median checker
// Port-level checks on the item channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_median_macros.svh"

module swm_checker import swm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] median_x2
);

	`SWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(median_x2), "result changed while stalled")
	`SWM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")
	`SWM_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without an accepted item")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

/* sim/sliding_window_median_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median testbench
// Streams signed samples through the block under several window sizes,
// predicts doubled medians from a sorted copy of the window (directed rows
// may give them), compares each output item in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
	import swm_pkg::*;

	localparam int                     QUIET_LIMIT = 4000;
	localparam int                     HOLD_CYCLES = 300;
	localparam int                     DRAIN_WAIT  = 8;
	localparam logic [ADDR_W-1:0]      WS_ADDR     = ADDR_W'(4 * REG_WINDOW_SIZE);
	localparam logic [ADDR_W-1:0]      SPARE_ADDR  = ADDR_W'(4);
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]    MED_MAX = {1'b0, {(OUT_W-2){1'b1}}, 1'b0};
	localparam logic signed [OUT_W-1:0]    MED_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct {
		bit                          is_cfg;
		logic [ADDR_W-1:0]           addr;
		logic [DATA_W-1:0]           wdata;
		logic signed [SAMPLE_W-1:0]  smp;
		bit                          sn;
		bit                          typed;
		logic signed [OUT_W-1:0]     med;
	} step_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [ADDR_W-1:0]          paddr = '0;
	logic [DATA_W-1:0]          pwdata = '0;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       start_new = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [OUT_W-1:0]    median_x2;
	logic                       out_valid;
	logic                       out_stall = 1'b0;

	logic signed [OUT_W-1:0]    median_q[$];
	logic signed [SAMPLE_W-1:0] arrival_q[$];
	logic signed [SAMPLE_W-1:0] sorted_q[$];
	logic [WS_W-1:0]            ws_reg = WS_RESET;
	logic signed [OUT_W-1:0]    median_want;
	int                         err_cnt = 0;
	int                         quiet_cnt = 0;
	bit                         idle_on = 1'b1;
	bit                         hold_req = 1'b0;
	step_t                      dir_tab[$];

	sliding_window_median i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sample    (sample),
		.start_new (start_new),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.median_x2 (median_x2),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned window_len();
		if (ws_reg == 0)
			return 1;
		if (ws_reg > WINDOW_MAX_DEF)
			return WINDOW_MAX_DEF;
		return ws_reg;
	endfunction

	function automatic void window_cfg(input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		if (addr == WS_ADDR) begin
			ws_reg = data[WS_W-1:0];
			arrival_q.delete();
			sorted_q.delete();
		end
	endfunction

	function automatic bit median_step(input logic signed [SAMPLE_W-1:0] s, input bit sn,
			output logic signed [OUT_W-1:0] med);
		int unsigned k;
		int          pos;
		longint      sum;
		k = window_len();
		med = '0;
		if (sn) begin
			arrival_q.delete();
			sorted_q.delete();
		end
		if (arrival_q.size() == k) begin
			for (int i = 0; i < sorted_q.size(); i++) begin
				if (sorted_q[i] == arrival_q[0]) begin
					sorted_q.delete(i);
					break;
				end
			end
			void'(arrival_q.pop_front());
		end
		pos = 0;
		while (pos < sorted_q.size() && sorted_q[pos] <= s)
			pos++;
		sorted_q.insert(pos, s);
		arrival_q.push_back(s);
		if (arrival_q.size() < k)
			return 1'b0;
		if (k % 2 == 1)
			sum = 2 * longint'(sorted_q[k/2]);
		else
			sum = longint'(sorted_q[k/2 - 1]) + longint'(sorted_q[k/2]);
		med = sum[OUT_W-1:0];
		return 1'b1;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		logic signed [SAMPLE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = SMP_MAX;
					1: v = SMP_MIN;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			1, 2, 3, 4: v = $signed(SAMPLE_W'($urandom_range(0, 16))) - 8;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic step_t row_item(input logic signed [SAMPLE_W-1:0] s, input bit sn,
			input bit typed = 1'b0, input logic signed [OUT_W-1:0] med = '0);
		step_t r;
		r = '{is_cfg: 1'b0, addr: '0, wdata: '0, smp: s, sn: sn, typed: typed, med: med};
		return r;
	endfunction

	function automatic step_t row_cfg(input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		step_t r;
		r = '{is_cfg: 1'b1, addr: addr, wdata: data, smp: '0, sn: 1'b0, typed: 1'b0,
			med: '0};
		return r;
	endfunction

	task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input bit sn,
			input bit typed = 1'b0, input logic signed [OUT_W-1:0] med = '0);
		logic signed [OUT_W-1:0] pred;
		bit                      has;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		sample    <= s;
		start_new <= sn;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		has = median_step(s, sn, pred);
		if (typed)
			median_q.push_back(med);
		else if (has)
			median_q.push_back(pred);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		window_cfg(addr, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_ws_read();
		logic [DATA_W-1:0] want;
		want = DATA_W'(ws_reg);
		@(negedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		paddr  <= WS_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want) begin
			$error("window_size: expected %0d, got %0d", want, prdata);
			err_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned ws, input int n, input bit pause_mid,
			input bit hold);
		int unsigned k;
		bit          sn;
		wait_idle();
		apb_write(WS_ADDR, DATA_W'(ws));
		check_ws_read();
		k = window_len();
		if (hold)
			hold_req = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				wait_idle();
			if (k > 16)
				sn = ($urandom_range(0, 299) == 0);
			else
				sn = ($urandom_range(0, 39) == 0);
			send_item(rand_sample(), sn);
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (median_q.size() == 0) begin
				$error("median_x2: no item expected, got %0d", median_x2);
				err_cnt++;
			end else begin
				median_want = median_q.pop_front();
				if (median_x2 !== median_want) begin
					$error("median_x2: expected %0d, got %0d", median_want, median_x2);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cnt <= 0;
		else
			quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned phase_ws[12];
		int          phase_len[12];
		phase_ws  = '{5, 1, 2, 64, 127, 3, 0, 8, 16, 100, 0, 7};
		phase_len = '{150, 80, 100, 220, 200, 120, 60, 150, 150, 160, 200, 150};
		phase_ws[10] = $urandom_range(1, 12);

		dir_tab.push_back(row_item(SMP_MAX, 1'b0));
		dir_tab.push_back(row_item(SMP_MAX, 1'b0));
		dir_tab.push_back(row_item(SMP_MAX, 1'b0, 1'b1, MED_MAX));
		dir_tab.push_back(row_item(SMP_MIN, 1'b0, 1'b1, MED_MAX));
		dir_tab.push_back(row_item(SMP_MIN, 1'b0, 1'b1, MED_MIN));
		dir_tab.push_back(row_item(SMP_MIN, 1'b0, 1'b1, MED_MIN));
		dir_tab.push_back(row_item(7, 1'b1));
		dir_tab.push_back(row_item(-3, 1'b0));
		dir_tab.push_back(row_item(7, 1'b0));
		dir_tab.push_back(row_cfg(WS_ADDR, 0));
		dir_tab.push_back(row_item(-1, 1'b0, 1'b1, -2));
		dir_tab.push_back(row_item(SMP_MAX, 1'b1, 1'b1, MED_MAX));
		dir_tab.push_back(row_cfg(WS_ADDR, 2));
		dir_tab.push_back(row_item(SMP_MAX, 1'b0));
		dir_tab.push_back(row_item(SMP_MAX, 1'b0, 1'b1, MED_MAX));
		dir_tab.push_back(row_item(SMP_MIN, 1'b0, 1'b1, -1));
		dir_tab.push_back(row_item(SMP_MIN, 1'b0, 1'b1, MED_MIN));
		dir_tab.push_back(row_cfg(SPARE_ADDR, 5));
		dir_tab.push_back(row_item(10, 1'b0));
		dir_tab.push_back(row_cfg(WS_ADDR, 4));
		dir_tab.push_back(row_item(1, 1'b0));
		dir_tab.push_back(row_item(2, 1'b0));
		dir_tab.push_back(row_item(3, 1'b0));
		dir_tab.push_back(row_item(4, 1'b0, 1'b1, 5));
		dir_tab.push_back(row_item(9, 1'b1));

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		check_ws_read();

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_idle();
				apb_write(dir_tab[i].addr, dir_tab[i].wdata);
				check_ws_read();
			end else begin
				send_item(dir_tab[i].smp, dir_tab[i].sn, dir_tab[i].typed, dir_tab[i].med);
			end
		end

		for (int p = 0; p < 12; p++) begin
			idle_on = (p % 3 != 2) && (p != 11);
			run_phase(phase_ws[p], phase_len[p], p == 3, p == 0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
